[rtl/core/moving_average_level_classifier_macros.svh]
// Assertion macros shared by the moving average level classifier RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef MOVING_AVERAGE_LEVEL_CLASSIFIER_MACROS_SVH
`define MOVING_AVERAGE_LEVEL_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MALC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/maclc_pkg.sv]
// Package for the moving average level classifier.
// Holds widths, reset values, register indexes, the level type and the threshold bundle.
`default_nettype none

package maclc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int LEVEL_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int DEFAULT_WINDOW_LENGTH = 10;

    localparam logic [SAMPLE_W-1:0] RESET_LOW_THRESHOLD = 12'd900;
    localparam logic [SAMPLE_W-1:0] RESET_HIGH_THRESHOLD = 12'd1500;
    localparam logic [SAMPLE_W-1:0] RESET_HYSTERESIS_MARGIN = 12'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_THRESHOLD = 2'd0,
        CFG_HIGH_THRESHOLD = 2'd1,
        CFG_HYSTERESIS_MARGIN = 2'd2
    } cfg_index_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_LOW = 2'd0,
        LEVEL_MEDIUM = 2'd1,
        LEVEL_HIGH = 2'd2
    } level_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_threshold;
        logic [SAMPLE_W-1:0] high_threshold;
        logic [SAMPLE_W-1:0] hysteresis_margin;
    } thresholds_t;

endpackage

`default_nettype wire

[rtl/core/maclc_window.sv]
// Sample window stage: a shift line of the most recent samples and the running sum.
// Depends on maclc_pkg.
`default_nettype none

module maclc_window #(
    parameter int WINDOW_LENGTH = maclc_pkg::DEFAULT_WINDOW_LENGTH,
    localparam int SUM_W = $clog2(WINDOW_LENGTH * maclc_pkg::SAMPLE_MAX + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [maclc_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [SUM_W-1:0]                   sum
);

    logic [maclc_pkg::SAMPLE_W-1:0] taps_reg [WINDOW_LENGTH];
    logic [SUM_W-1:0]               sum_reg;
    logic [SUM_W-1:0]               sum_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic                           load;

    assign in_ready = !valid_reg || out_ready;
    assign load = in_valid && in_ready;

    // The oldest sample leaves the sum as the new one enters it.
    assign sum_next = sum_reg - SUM_W'(taps_reg[WINDOW_LENGTH-1]) + SUM_W'(sample);
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                taps_reg[i] <= '0;
            end
            sum_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                taps_reg[0] <= sample;
                for (int i = 1; i < WINDOW_LENGTH; i++)
                begin
                    taps_reg[i] <= taps_reg[i-1];
                end
                sum_reg <= sum_next;
            end
        end
    end

    assign out_valid = valid_reg;
    assign sum = sum_reg;

endmodule

`default_nettype wire

[rtl/core/maclc_divide.sv]
// Average stage: divides the running sum by the window length with a reciprocal multiply.
// Depends on maclc_pkg.
`default_nettype none

module maclc_divide #(
    parameter int WINDOW_LENGTH = maclc_pkg::DEFAULT_WINDOW_LENGTH,
    localparam int SUM_W = $clog2(WINDOW_LENGTH * maclc_pkg::SAMPLE_MAX + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [SUM_W-1:0]               sum,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [maclc_pkg::SAMPLE_W-1:0]      average
);

    // With SHIFT = SUM_W + ceil(log2(length)) the rounded-up reciprocal gives the exact
    // truncated quotient for every sum that fits in SUM_W bits.
    localparam int SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

    logic [PROD_W-1:0]                 product;
    logic [PROD_W-1:0]                 quotient;
    logic [maclc_pkg::SAMPLE_W-1:0]    average_reg;
    logic                              valid_reg;
    logic                              load;

    assign in_ready = !valid_reg || out_ready;
    assign load = in_valid && in_ready;

    assign product = {{RECIP_W{1'b0}}, sum} * PROD_W'(RECIP);
    assign quotient = product >> SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load || (valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            average_reg <= quotient[maclc_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign average = average_reg;

endmodule

`default_nettype wire

[rtl/core/maclc_classify.sv]
// Hysteresis classifier stage and result register.
// Depends on maclc_pkg for the level type and the threshold bundle.
`default_nettype none

module maclc_classify (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire maclc_pkg::thresholds_t         thresholds,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [maclc_pkg::SAMPLE_W-1:0] average_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [maclc_pkg::SAMPLE_W-1:0]      average,
    output logic [maclc_pkg::LEVEL_W-1:0]       level,
    output logic                                level_changed
);

    maclc_pkg::level_t                 level_reg;
    maclc_pkg::level_t                 level_next;
    logic                              changed_reg;
    logic                              changed_next;
    logic [maclc_pkg::SAMPLE_W-1:0]    average_reg;
    logic                              valid_reg;
    logic                              load;
    logic [maclc_pkg::SAMPLE_W:0]      low_up_bound;
    logic [maclc_pkg::SAMPLE_W:0]      high_up_bound;
    logic                              below_low;
    logic                              below_high;

    assign in_ready = !valid_reg || out_ready;
    assign load = in_valid && in_ready;

    // Upward bounds are formed one bit wider so that they never wrap.
    assign low_up_bound = {1'b0, thresholds.low_threshold} + {1'b0, thresholds.hysteresis_margin};
    assign high_up_bound = {1'b0, thresholds.high_threshold} + {1'b0, thresholds.hysteresis_margin};
    assign below_low = average_in < thresholds.low_threshold;
    assign below_high = average_in < thresholds.high_threshold;

    always_comb
    begin
        level_next = maclc_pkg::LEVEL_LOW;
        unique case (level_reg)
            maclc_pkg::LEVEL_MEDIUM:
            begin
                if (below_low)
                begin
                    level_next = maclc_pkg::LEVEL_LOW;
                end
                else if ({1'b0, average_in} >= high_up_bound)
                begin
                    level_next = maclc_pkg::LEVEL_HIGH;
                end
                else
                begin
                    level_next = maclc_pkg::LEVEL_MEDIUM;
                end
            end
            maclc_pkg::LEVEL_HIGH:
            begin
                if (below_low)
                begin
                    level_next = maclc_pkg::LEVEL_LOW;
                end
                else if (below_high)
                begin
                    level_next = maclc_pkg::LEVEL_MEDIUM;
                end
                else
                begin
                    level_next = maclc_pkg::LEVEL_HIGH;
                end
            end
            default:
            begin
                if (!below_high)
                begin
                    level_next = maclc_pkg::LEVEL_HIGH;
                end
                else if ({1'b0, average_in} >= low_up_bound)
                begin
                    level_next = maclc_pkg::LEVEL_MEDIUM;
                end
                else
                begin
                    level_next = maclc_pkg::LEVEL_LOW;
                end
            end
        endcase
    end

    always_comb
    begin
        changed_next = level_next != level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= maclc_pkg::LEVEL_LOW;
            changed_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load || (valid_reg && !out_ready);
            if (load)
            begin
                level_reg <= level_next;
                changed_reg <= changed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            average_reg <= average_in;
        end
    end

    assign out_valid = valid_reg;
    assign average = average_reg;
    assign level = level_reg;
    assign level_changed = changed_reg;

endmodule

`default_nettype wire

[rtl/core/moving_average_level_classifier.sv]
// Depends on maclc_pkg and the macros. A request accepted into the window register passes
// through the average register and then the result register, where its result can be taken.
// Throughput: one request per cycle while result_ready is high; each of the three stages
// (window and running sum, reciprocal multiply, classifier) holds one request and advances
// whenever the next has room. Reset clears the sample window, the running sum and the level
// to low, empties the pipeline, and loads the thresholds with 900, 1500 and margin 50.
`default_nettype none

`include "moving_average_level_classifier_macros.svh"

module moving_average_level_classifier #(
    parameter int WINDOW_LENGTH = maclc_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_enable,
    input  wire logic [maclc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [maclc_pkg::SAMPLE_W-1:0]    cfg_data,
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic [maclc_pkg::SAMPLE_W-1:0]    sample,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [maclc_pkg::SAMPLE_W-1:0]         average,
    output logic [maclc_pkg::LEVEL_W-1:0]          level,
    output logic                                   level_changed
);

    localparam int SUM_W = $clog2(WINDOW_LENGTH * maclc_pkg::SAMPLE_MAX + 1);

    maclc_pkg::thresholds_t            thresholds_reg;
    logic                              sum_valid;
    logic                              sum_ready;
    logic [SUM_W-1:0]                  sum;
    logic                              avg_valid;
    logic                              avg_ready;
    logic [maclc_pkg::SAMPLE_W-1:0]    avg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.low_threshold <= maclc_pkg::RESET_LOW_THRESHOLD;
            thresholds_reg.high_threshold <= maclc_pkg::RESET_HIGH_THRESHOLD;
            thresholds_reg.hysteresis_margin <= maclc_pkg::RESET_HYSTERESIS_MARGIN;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                maclc_pkg::CFG_LOW_THRESHOLD:
                begin
                    thresholds_reg.low_threshold <= cfg_data;
                end
                maclc_pkg::CFG_HIGH_THRESHOLD:
                begin
                    thresholds_reg.high_threshold <= cfg_data;
                end
                maclc_pkg::CFG_HYSTERESIS_MARGIN:
                begin
                    thresholds_reg.hysteresis_margin <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    maclc_window #(
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) u_window (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(sample_valid),
        .in_ready(sample_ready),
        .sample(sample),
        .out_valid(sum_valid),
        .out_ready(sum_ready),
        .sum(sum)
    );

    maclc_divide #(
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) u_divide (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(sum_valid),
        .in_ready(sum_ready),
        .sum(sum),
        .out_valid(avg_valid),
        .out_ready(avg_ready),
        .average(avg)
    );

    maclc_classify u_classify (
        .clk(clk),
        .rst_n(rst_n),
        .thresholds(thresholds_reg),
        .in_valid(avg_valid),
        .in_ready(avg_ready),
        .average_in(avg),
        .out_valid(result_valid),
        .out_ready(result_ready),
        .average(average),
        .level(level),
        .level_changed(level_changed)
    );

    `MALC_ASSERT_NEXT(a_request_enters_window, sample_valid && sample_ready, sum_valid,
        "accepted request did not reach the window stage")
    `MALC_ASSERT_SAME(a_sum_in_range, sum_valid,
        sum <= SUM_W'(WINDOW_LENGTH * maclc_pkg::SAMPLE_MAX),
        "running sum exceeds the largest possible window total")
    `MALC_ASSERT_NEXT(a_no_result_from_nothing, result_valid && result_ready && !avg_valid,
        !result_valid, "result appeared without an average to classify")

endmodule

`default_nettype wire
